### rtl/rhmc_pkg.sv
package rhmc_pkg;

    localparam int UNIT_W              = 16;
    localparam int HASH_W              = 64;
    localparam int LEN_W               = 9;
    localparam int COUNT_W             = 31;
    localparam int CFG_IDX_W           = 2;
    localparam int DEFAULT_MAX_PATTERN = 256;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [HASH_W-1:0]  MULT_RESET  = 64'd31;
    localparam logic [LEN_W-1:0]   LEN_RESET   = 9'd1;
    localparam logic [HASH_W-1:0]  PHASH_RESET = 64'd0;
    localparam logic [HASH_W-1:0]  MPOW_RESET  = 64'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MULT  = 2'd0,
        CFG_LEN   = 2'd1,
        CFG_PHASH = 2'd2,
        CFG_MPOW  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [UNIT_W-1:0] outgoing;
        logic [UNIT_W-1:0] unit;
        logic              first;
        logic              last;
        logic              cmp;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### rtl/rhmc_front.sv
module rhmc_front #(
    parameter int MAX_PATTERN = rhmc_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rhmc_pkg::LEN_W-1:0]    i_len,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [rhmc_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                          i_first_of_file,
    input  logic                          i_last_of_file,
    output logic                          o_q_push,
    output rhmc_pkg::t_job                o_q_job,
    input  rhmc_pkg::t_q_stat             i_q_stat
);

    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SW = $clog2(MAX_PATTERN + 1);
    localparam int LW = (SW > rhmc_pkg::LEN_W) ? SW : rhmc_pkg::LEN_W;
    localparam int DW = SW + 1;

    localparam logic [LW-1:0] MAX_L  = LW'(MAX_PATTERN);
    localparam logic [SW-1:0] MAX_S  = SW'(MAX_PATTERN);
    localparam logic [DW-1:0] MAX_D  = DW'(MAX_PATTERN);
    localparam logic [AW-1:0] LAST_A = AW'(MAX_PATTERN - 1);

    logic [rhmc_pkg::UNIT_W-1:0] r_mem [MAX_PATTERN];
    logic [rhmc_pkg::UNIT_W-1:0] r_rd;
    logic [AW-1:0]               r_wp;
    logic [SW-1:0]               r_seen;
    logic                        r_s1_valid;
    logic [rhmc_pkg::UNIT_W-1:0] r_s1_unit;
    logic                        r_s1_first;
    logic                        r_s1_last;
    logic                        r_s1_use_out;
    logic                        r_s1_cmp;

    logic [LW-1:0] len_ext;
    logic [SW-1:0] eff_len;
    logic [SW-1:0] seen_cur;
    logic [SW-1:0] n_seen;
    logic [AW-1:0] n_wp;
    logic [DW-1:0] wp_d;
    logic [DW-1:0] len_d;
    logic [DW-1:0] rd_d;
    logic [AW-1:0] raddr;
    logic          use_out;
    logic          cmp;
    logic          accept;

    assign len_ext = LW'(i_len);

    always_comb begin
        if (len_ext == '0) begin
            eff_len = SW'(1);
        end else if (len_ext > MAX_L) begin
            eff_len = MAX_S;
        end else begin
            eff_len = len_ext[SW-1:0];
        end
    end

    assign seen_cur = i_first_of_file ? '0 : r_seen;
    assign use_out  = (seen_cur >= eff_len);
    assign n_seen   = (seen_cur == MAX_S) ? seen_cur : seen_cur + SW'(1);
    assign cmp      = (n_seen >= eff_len);

    // unit that arrived len beats ago, on a circular delay line
    assign wp_d  = DW'(r_wp);
    assign len_d = DW'(eff_len);
    assign rd_d  = (wp_d >= len_d) ? (wp_d - len_d) : (wp_d + MAX_D - len_d);
    assign raddr = rd_d[AW-1:0];
    assign n_wp  = (r_wp == LAST_A) ? '0 : r_wp + AW'(1);

    assign o_full   = r_s1_valid && i_q_stat.full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_s1_valid && !i_q_stat.full;

    assign o_q_job.outgoing = r_s1_use_out ? r_rd : '0;
    assign o_q_job.unit     = r_s1_unit;
    assign o_q_job.first    = r_s1_first;
    assign o_q_job.last     = r_s1_last;
    assign o_q_job.cmp      = r_s1_cmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp       <= '0;
            r_seen     <= '0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
            r_wp       <= n_wp;
            r_seen     <= n_seen;
        end else if (!i_q_stat.full) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_unit    <= i_code_unit;
            r_s1_first   <= i_first_of_file;
            r_s1_last    <= i_last_of_file;
            r_s1_use_out <= use_out;
            r_s1_cmp     <= cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd        <= r_mem[raddr];
            r_mem[r_wp] <= i_code_unit;
        end
    end

endmodule

### rtl/rhmc_fifo.sv
module rhmc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rhmc_pkg::t_job    i_job,
    input  logic              i_pop,
    output rhmc_pkg::t_job    o_job,
    output rhmc_pkg::t_q_stat o_stat
);

    localparam int DEPTH = rhmc_pkg::QUEUE_DEPTH;
    localparam int QAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCW   = $clog2(DEPTH + 1);

    localparam logic [QAW-1:0] LAST_Q = QAW'(DEPTH - 1);
    localparam logic [QCW-1:0] FULL_C = QCW'(DEPTH);

    rhmc_pkg::t_job r_mem [DEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == FULL_C);
    assign o_stat.empty = (r_cnt == '0);
    assign o_job        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_Q) ? '0 : r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_Q) ? '0 : r_rd + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

### rtl/rhmc_back.sv
module rhmc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rhmc_pkg::HASH_W-1:0]   i_mult,
    input  logic [rhmc_pkg::HASH_W-1:0]   i_phash,
    input  logic [rhmc_pkg::HASH_W-1:0]   i_mpow,
    input  rhmc_pkg::t_job                i_job,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_window_match,
    output logic [rhmc_pkg::COUNT_W-1:0]  o_match_count,
    output logic                          o_file_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SUB,
        S_M0,
        S_M1,
        S_M2,
        S_FIN
    } t_state;

    t_state                        r_state;
    rhmc_pkg::t_job                r_job;
    logic [rhmc_pkg::HASH_W-1:0]   r_prod;
    logic [rhmc_pkg::HASH_W-1:0]   r_t;
    logic [rhmc_pkg::HASH_W-1:0]   r_acc;
    logic [rhmc_pkg::HASH_W-1:0]   r_hash;
    logic [rhmc_pkg::COUNT_W-1:0]  r_count;
    logic                          r_out_valid;
    logic                          r_out_match;
    logic [rhmc_pkg::COUNT_W-1:0]  r_out_count;
    logic                          r_out_done;

    logic [47:0]                   prod_lo;
    logic [31:0]                   prod_hi;
    logic [rhmc_pkg::HASH_W-1:0]   prod;
    logic [rhmc_pkg::HASH_W-1:0]   hash_base;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [63:0]                   mul_p;
    logic [rhmc_pkg::COUNT_W-1:0]  count_base;
    logic [rhmc_pkg::COUNT_W-1:0]  count_new;
    logic                          match;
    logic                          out_free;
    logic                          out_load;

    // outgoing unit times multiplier^len, low 64 bits
    assign prod_lo = {32'b0, r_job.outgoing} * {16'b0, i_mpow[31:0]};
    assign prod_hi = 32'({16'b0, r_job.outgoing} * i_mpow[63:32]);
    assign prod    = {16'b0, prod_lo} + {prod_hi, 32'b0};

    assign hash_base = r_job.first ? '0 : r_hash;

    // shared 32x32 multiplier, three passes for the low 64 bits
    assign mul_a = (r_state == S_M2) ? r_t[63:32] : r_t[31:0];
    assign mul_b = (r_state == S_M1) ? i_mult[63:32] : i_mult[31:0];
    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    assign count_base = r_job.first ? '0 : r_count;
    assign match      = r_job.cmp && (r_acc == i_phash);
    assign count_new  = (match && (count_base != rhmc_pkg::COUNT_MAX))
                        ? count_base + rhmc_pkg::COUNT_W'(1) : count_base;

    assign out_free = !r_out_valid || i_pop;
    assign out_load = (r_state == S_FIN) && out_free;
    assign o_q_pop  = ((r_state == S_IDLE) || ((r_state == S_FIN) && out_free)) && !i_q_empty;

    assign o_empty        = !r_out_valid;
    assign o_window_match = r_out_match;
    assign o_match_count  = r_out_count;
    assign o_file_done    = r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hash      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_job   <= i_job;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_prod  <= prod;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_t     <= hash_base - r_prod + {48'b0, r_job.unit};
                    r_state <= S_M0;
                end
                S_M0: begin
                    r_acc   <= mul_p;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
                    r_state      <= S_M2;
                end
                S_M2: begin
                    r_acc[63:32] <= r_acc[63:32] + mul_p[31:0];
                    r_state      <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_hash      <= r_acc;
                        r_count     <= count_new;
                        r_out_match <= match;
                        r_out_count <= count_new;
                        r_out_done  <= r_job.last;
                        if (o_q_pop) begin
                            r_job   <= i_job;
                            r_state <= S_PROD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_match_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_match) |-> (r_out_count != '0))
        else $error("match beat with zero count");

    a_fin_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_out_valid && !i_pop) |=> (r_state == S_FIN))
        else $error("result dropped while output blocked");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> ((r_state == S_IDLE) || (r_state == S_FIN)))
        else $error("queue popped while busy");
`endif

endmodule

### rtl/rolling_hash_match_counter_top.sv
// Counts the positions in a file where the 64-bit polynomial rolling hash of
// the last pattern_length code units equals pattern_hash; software loads the
// multiplier, pattern_length, pattern_hash and multiplier^pattern_length
// through the write port while the block is idle. Each code unit gives one
// result beat with the match flag, the saturating count for the file and the
// last-unit flag. The front end takes one unit per cycle into a short queue,
// stalling while the queue is full; the back end takes the next unit only once
// the last is finished, stepping through the hash update: the outgoing-unit
// product, the subtract, and the 64-bit multiply by the base run in three
// passes through one 32x32 multiplier. No clearing pass follows reset;
// delay-line entries are read only after being written in this file.
module rolling_hash_match_counter_top #(
    parameter int MAX_PATTERN = rhmc_pkg::DEFAULT_MAX_PATTERN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rhmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rhmc_pkg::HASH_W-1:0]     i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [rhmc_pkg::UNIT_W-1:0]     i_code_unit,
    input  logic                            i_first_of_file,
    input  logic                            i_last_of_file,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_window_match,
    output logic [rhmc_pkg::COUNT_W-1:0]    o_match_count,
    output logic                            o_file_done
);

    logic [rhmc_pkg::HASH_W-1:0] r_mult;
    logic [rhmc_pkg::LEN_W-1:0]  r_len;
    logic [rhmc_pkg::HASH_W-1:0] r_phash;
    logic [rhmc_pkg::HASH_W-1:0] r_mpow;

    logic              q_push;
    logic              q_pop;
    rhmc_pkg::t_job    q_in;
    rhmc_pkg::t_job    q_out;
    rhmc_pkg::t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult  <= rhmc_pkg::MULT_RESET;
            r_len   <= rhmc_pkg::LEN_RESET;
            r_phash <= rhmc_pkg::PHASH_RESET;
            r_mpow  <= rhmc_pkg::MPOW_RESET;
        end else if (i_cfg_we) begin
            unique case (rhmc_pkg::t_cfg_idx'(i_cfg_index))
                rhmc_pkg::CFG_MULT:  r_mult  <= i_cfg_data;
                rhmc_pkg::CFG_LEN:   r_len   <= i_cfg_data[rhmc_pkg::LEN_W-1:0];
                rhmc_pkg::CFG_PHASH: r_phash <= i_cfg_data;
                rhmc_pkg::CFG_MPOW:  r_mpow  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rhmc_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len           (r_len),
        .i_push          (push),
        .o_full          (full),
        .i_code_unit     (i_code_unit),
        .i_first_of_file (i_first_of_file),
        .i_last_of_file  (i_last_of_file),
        .o_q_push        (q_push),
        .o_q_job         (q_in),
        .i_q_stat        (q_stat)
    );

    rhmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_job   (q_out),
        .o_stat  (q_stat)
    );

    rhmc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mult         (r_mult),
        .i_phash        (r_phash),
        .i_mpow         (r_mpow),
        .i_job          (q_out),
        .i_q_empty      (q_stat.empty),
        .o_q_pop        (q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_window_match (o_window_match),
        .o_match_count  (o_match_count),
        .o_file_done    (o_file_done)
    );

endmodule
